FILE: hdl/lz4d_pkg.sv
// Shared types and constants of the LZ4 block decoder.
`default_nettype none
package lz4d_pkg;

  localparam int WINDOW_BYTES = 65536;
  localparam int WIN_W        = 16;
  localparam int MIN_MATCH    = 4;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_TRUNC_LLEN = 3'd1;
  localparam logic [2:0] ERR_TRUNC_LITS = 3'd2;
  localparam logic [2:0] ERR_TRUNC_OFF  = 3'd3;
  localparam logic [2:0] ERR_ZERO_OFF   = 3'd4;
  localparam logic [2:0] ERR_FAR_OFF    = 3'd5;
  localparam logic [2:0] ERR_TRUNC_MLEN = 3'd6;
  localparam logic [2:0] ERR_SIZE       = 3'd7;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } item_t;

  typedef struct packed {
    logic [63:0] out_bytes;
    logic [3:0]  out_count;
    logic        out_last;
    logic [2:0]  error_code;
  } result_t;

  typedef enum logic [1:0] {
    CMD_LIT,
    CMD_MATCH,
    CMD_CLOSE
  } cmd_kind_t;

  // data: literal byte or match length; distance: match offset; code: close status
  typedef struct packed {
    cmd_kind_t        kind;
    logic [7:0]       data;
    logic [WIN_W-1:0] distance;
    logic [2:0]       code;
  } cmd_t;

endpackage
`default_nettype wire

FILE: hdl/lz4d_fifo.sv
// Small synchronous FIFO used between the decoder stages.
`default_nettype none
module lz4d_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr,
  input  wire logic [W-1:0]               din,
  input  wire logic                       rd,
  output logic [W-1:0]                    dout,
  output logic                            empty,
  output logic                            full,
  output logic [$clog2(DEPTH+1)-1:0]      level
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;

  logic do_wr;
  logic do_rd;

  assign empty = (level == '0);
  assign full  = (level == ($clog2(DEPTH+1))'(DEPTH));
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        level <= level + 1'b1;
      end else if (do_rd && !do_wr) begin
        level <= level - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= din;
    end
  end
endmodule
`default_nettype wire

FILE: hdl/lz4d_front.sv
// Front end: parses compressed bytes, checks errors, issues copy commands.
`default_nettype none
module lz4d_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire lz4d_pkg::item_t item,
  output logic                 full,
  input  wire logic            room,
  input  wire logic            cfg_valid,
  input  wire logic [31:0]     cfg_data,
  output logic                 cmd_push,
  output lz4d_pkg::cmd_t       cmd
);
  typedef enum logic [2:0] {
    PH_TOKEN, PH_LITLEN, PH_LITS, PH_OFF_LO, PH_OFF_HI, PH_MATLEN, PH_DRAIN
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] pc, pc_next;
  logic [31:0] lit_left, lit_left_next;
  logic [3:0]  nib, nib_next;
  logic [15:0] distance, distance_next;
  logic [2:0]  err, err_next;
  logic        pend, pend_next;
  logic [2:0]  pend_code, pend_code_next;
  logic [31:0] expected_size;

  logic        accept;
  logic        raise;
  logic [2:0]  rcode;
  logic        cp;
  logic [7:0]  cp_n;
  logic        lit_out;
  logic [32:0] sum;
  logic [15:0] d;
  logic [2:0]  close_code;
  logic        data_cmd;

  assign full   = pend || !room;
  assign accept = push && !full;

  always_comb begin
    phase_next     = phase;
    pc_next        = pc;
    lit_left_next  = lit_left;
    nib_next       = nib;
    distance_next  = distance;
    err_next       = err;
    pend_next      = pend;
    pend_code_next = pend_code;
    raise          = 1'b0;
    rcode          = lz4d_pkg::ERR_NONE;
    cp             = 1'b0;
    cp_n           = '0;
    lit_out        = 1'b0;
    data_cmd       = 1'b0;
    close_code     = lz4d_pkg::ERR_NONE;
    sum            = '0;
    d              = {item.in_byte, distance[7:0]};
    cmd_push       = 1'b0;
    cmd            = '0;

    if (pend) begin
      cmd_push   = 1'b1;
      cmd.kind   = lz4d_pkg::CMD_CLOSE;
      cmd.code   = pend_code;
      pend_next  = 1'b0;
    end else if (accept) begin
      case (phase)
        PH_TOKEN: begin
          nib_next = item.in_byte[3:0];
          if (item.in_byte[7:4] == 4'hf) begin
            lit_left_next = 32'd15;
            if (item.in_last) begin
              raise = 1'b1; rcode = lz4d_pkg::ERR_TRUNC_LLEN;
            end else begin
              phase_next = PH_LITLEN;
            end
          end else if (item.in_byte[7:4] != 4'h0) begin
            lit_left_next = {28'b0, item.in_byte[7:4]};
            if (item.in_last) begin
              raise = 1'b1; rcode = lz4d_pkg::ERR_TRUNC_LITS;
            end else begin
              phase_next = PH_LITS;
            end
          end else begin
            phase_next = PH_OFF_LO;
          end
        end
        PH_LITLEN: begin
          sum = {1'b0, lit_left} + {25'b0, item.in_byte};
          lit_left_next = sum[32] ? 32'hffff_ffff : sum[31:0];
          if (item.in_byte == 8'hff) begin
            if (item.in_last) begin
              raise = 1'b1; rcode = lz4d_pkg::ERR_TRUNC_LLEN;
            end
          end else if (item.in_last) begin
            raise = 1'b1; rcode = lz4d_pkg::ERR_TRUNC_LITS;
          end else begin
            phase_next = PH_LITS;
          end
        end
        PH_LITS: begin
          if (pc == 32'hffff_ffff) begin
            raise = 1'b1; rcode = lz4d_pkg::ERR_SIZE;
          end else begin
            lit_out       = 1'b1;
            pc_next       = pc + 32'd1;
            lit_left_next = lit_left - 32'd1;
            if (lit_left == 32'd1) begin
              phase_next = PH_OFF_LO;
            end else if (item.in_last) begin
              raise = 1'b1; rcode = lz4d_pkg::ERR_TRUNC_LITS;
            end
          end
        end
        PH_OFF_LO: begin
          distance_next = {8'b0, item.in_byte};
          if (item.in_last) begin
            raise = 1'b1; rcode = lz4d_pkg::ERR_TRUNC_OFF;
          end else begin
            phase_next = PH_OFF_HI;
          end
        end
        PH_OFF_HI: begin
          distance_next = d;
          if (d == 16'd0) begin
            raise = 1'b1; rcode = lz4d_pkg::ERR_ZERO_OFF;
          end else if ({16'b0, d} > pc) begin
            raise = 1'b1; rcode = lz4d_pkg::ERR_FAR_OFF;
          end else if (nib == 4'hf) begin
            if (item.in_last) begin
              raise = 1'b1; rcode = lz4d_pkg::ERR_TRUNC_MLEN;
            end else begin
              phase_next = PH_MATLEN;
              cp = 1'b1; cp_n = 8'd15 + 8'(lz4d_pkg::MIN_MATCH);
            end
          end else begin
            phase_next = PH_TOKEN;
            cp = 1'b1; cp_n = {4'b0, nib} + 8'(lz4d_pkg::MIN_MATCH);
          end
        end
        PH_MATLEN: begin
          if (item.in_byte == 8'hff) begin
            if (item.in_last) begin
              raise = 1'b1; rcode = lz4d_pkg::ERR_TRUNC_MLEN;
            end else begin
              cp = 1'b1; cp_n = 8'hff;
            end
          end else begin
            phase_next = PH_TOKEN;
            cp = 1'b1; cp_n = item.in_byte;
          end
        end
        default: begin
        end
      endcase

      // match copy with output size check
      if (cp && cp_n != 8'd0) begin
        sum = {1'b0, pc} + {25'b0, cp_n};
        if (sum[32]) begin
          raise = 1'b1; rcode = lz4d_pkg::ERR_SIZE;
        end else begin
          pc_next       = sum[31:0];
          data_cmd      = 1'b1;
          cmd.kind      = lz4d_pkg::CMD_MATCH;
          cmd.data      = cp_n;
          cmd.distance  = distance_next;
        end
      end
      if (lit_out) begin
        data_cmd = 1'b1;
        cmd.kind = lz4d_pkg::CMD_LIT;
        cmd.data = item.in_byte;
      end

      if (raise) begin
        if (err == lz4d_pkg::ERR_NONE) begin
          err_next = rcode;
        end
        phase_next = PH_DRAIN;
      end

      if (item.in_last) begin
        close_code = err_next;
        if (err_next == lz4d_pkg::ERR_NONE && pc_next != expected_size) begin
          close_code = lz4d_pkg::ERR_SIZE;
        end
        if (data_cmd) begin
          pend_next      = 1'b1;
          pend_code_next = close_code;
        end else begin
          cmd.kind = lz4d_pkg::CMD_CLOSE;
          cmd.code = close_code;
        end
        phase_next    = PH_TOKEN;
        pc_next       = '0;
        lit_left_next = '0;
        nib_next      = '0;
        distance_next = '0;
        err_next      = lz4d_pkg::ERR_NONE;
      end
      cmd_push = data_cmd || item.in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_TOKEN;
      pc            <= '0;
      lit_left      <= '0;
      nib           <= '0;
      distance      <= '0;
      err           <= lz4d_pkg::ERR_NONE;
      pend          <= 1'b0;
      pend_code     <= lz4d_pkg::ERR_NONE;
      expected_size <= '0;
    end else begin
      phase     <= phase_next;
      pc        <= pc_next;
      lit_left  <= lit_left_next;
      nib       <= nib_next;
      distance  <= distance_next;
      err       <= err_next;
      pend      <= pend_next;
      pend_code <= pend_code_next;
      if (cfg_valid) begin
        expected_size <= cfg_data;
      end
    end
  end
endmodule
`default_nettype wire

FILE: hdl/lz4d_back.sv
// Back end: history memory, match copy and result packing.
`default_nettype none
module lz4d_back #(
  parameter int OUT_LANES = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cmd_empty,
  input  wire lz4d_pkg::cmd_t   cmd,
  output logic                  cmd_pop,
  input  wire logic             res_full,
  output logic                  res_push,
  output lz4d_pkg::result_t     res
);
  localparam int AW = lz4d_pkg::WIN_W;

  typedef enum logic [1:0] {B_IDLE, B_RD, B_WR, B_PUSH} bstate_t;

  bstate_t     st;
  logic [AW-1:0] wpos;
  logic [AW-1:0] distance;
  logic [7:0]  rem;
  logic [63:0] acc;
  logic [3:0]  lanes;
  logic [7:0]  rd_data;
  logic [7:0]  mem [lz4d_pkg::WINDOW_BYTES];

  logic        we;
  logic [7:0]  wdata;
  logic [63:0] acc_new;
  logic [3:0]  lanes_new;

  assign cmd_pop   = (st == B_IDLE) && !cmd_empty;
  assign res_push  = (st == B_PUSH) && !res_full;
  assign acc_new   = acc | ({56'b0, rd_data} << {lanes, 3'b000});
  assign lanes_new = lanes + 4'd1;

  always_comb begin
    we    = 1'b0;
    wdata = rd_data;
    if (st == B_IDLE && !cmd_empty && cmd.kind == lz4d_pkg::CMD_LIT) begin
      we    = 1'b1;
      wdata = cmd.data;
    end else if (st == B_WR) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wpos] <= wdata;
    end
    if (st == B_RD) begin
      rd_data <= mem[wpos - distance];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= B_IDLE;
      wpos <= '0;
      rem  <= '0;
    end else begin
      case (st)
        B_IDLE: begin
          if (!cmd_empty) begin
            case (cmd.kind)
              lz4d_pkg::CMD_LIT: begin
                res  <= '{out_bytes: {56'b0, cmd.data}, out_count: 4'd1,
                          out_last: 1'b0, error_code: lz4d_pkg::ERR_NONE};
                wpos <= wpos + 1'b1;
                rem  <= '0;
                st   <= B_PUSH;
              end
              lz4d_pkg::CMD_MATCH: begin
                rem      <= cmd.data;
                distance <= cmd.distance;
                acc      <= '0;
                lanes    <= '0;
                st       <= B_RD;
              end
              default: begin
                res  <= '{out_bytes: 64'b0, out_count: 4'd0,
                          out_last: 1'b1, error_code: cmd.code};
                wpos <= '0;
                rem  <= '0;
                st   <= B_PUSH;
              end
            endcase
          end
        end
        B_RD: begin
          st <= B_WR;
        end
        B_WR: begin
          acc   <= acc_new;
          lanes <= lanes_new;
          wpos  <= wpos + 1'b1;
          rem   <= rem - 8'd1;
          if (lanes_new == 4'(OUT_LANES) || rem == 8'd1) begin
            res <= '{out_bytes: acc_new, out_count: lanes_new,
                     out_last: 1'b0, error_code: lz4d_pkg::ERR_NONE};
            st  <= B_PUSH;
          end else begin
            st <= B_RD;
          end
        end
        B_PUSH: begin
          if (!res_full) begin
            acc   <= '0;
            lanes <= '0;
            st    <= (rem != 8'd0) ? B_RD : B_IDLE;
          end
        end
        default: begin
          st <= B_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: hdl/lz4_block_decoder.sv
// Top level of the streaming LZ4 block decoder.
// A literal byte passes the command queue, result register and result queue. Bytes
// enter at one per cycle while at most 2 commands are queued and no close is pending;
// the copy engine reads then writes each match byte and takes new commands when idle.
// Reset (rst, synchronous): clears parser, queues and expected_size; history is
// left unwritten and is never read before it is filled.
`default_nettype none
module lz4_block_decoder #(
  parameter int OUT_LANES = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // compressed byte words
  input  wire logic               push,
  input  wire lz4d_pkg::item_t    item,
  output logic                    full,
  // decoded result words
  input  wire logic               pop,
  output logic                    empty,
  output lz4d_pkg::result_t       result,
  // expected decompressed size
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [31:0]        cfg_data
);
  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 4;
  localparam int CW = $bits(lz4d_pkg::cmd_t);
  localparam int RW = $bits(lz4d_pkg::result_t);

  logic                             cmd_push;
  lz4d_pkg::cmd_t                   cmd_in;
  lz4d_pkg::cmd_t                   cmd_out;
  logic [CW-1:0]                    cmd_out_raw;
  logic                             cmd_pop;
  logic                             cmd_empty;
  logic                             cmd_full;
  logic [$clog2(CMD_DEPTH+1)-1:0]   cmd_level;
  logic                             room;

  logic                             res_push;
  logic                             res_full;
  lz4d_pkg::result_t                res_in;
  logic [RW-1:0]                    res_out_raw;
  logic [$clog2(RES_DEPTH+1)-1:0]   res_level;

  assign cfg_ready = 1'b1;
  // front may issue a data command and then a close command per byte
  assign room    = (cmd_level <= ($clog2(CMD_DEPTH+1))'(CMD_DEPTH-2));
  assign cmd_out = lz4d_pkg::cmd_t'(cmd_out_raw);
  assign result  = lz4d_pkg::result_t'(res_out_raw);

  lz4d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .room      (room),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  lz4d_fifo #(.W(CW), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (cmd_push),
    .din   (CW'(cmd_in)),
    .rd    (cmd_pop),
    .dout  (cmd_out_raw),
    .empty (cmd_empty),
    .full  (cmd_full),
    .level (cmd_level)
  );

  lz4d_back #(.OUT_LANES(OUT_LANES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  lz4d_fifo #(.W(RW), .DEPTH(RES_DEPTH)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_push),
    .din   (RW'(res_in)),
    .rd    (pop),
    .dout  (res_out_raw),
    .empty (empty),
    .full  (res_full),
    .level (res_level)
  );

  // queue level and command full flag are informational only
  logic unused_level;
  assign unused_level = ^{res_level, cmd_full};
endmodule
`default_nettype wire
